FILE: src/gplv_pkg.sv
// gplv_pkg: shared constants and types for the gated plurality label vote
// no dependencies

package gplv_pkg;

  localparam int LANE_COUNT      = 8;
  localparam int NUM_VOTERS_DEF  = 8;
  localparam int LABEL_WIDTH_DEF = 8;

  localparam int VOTE_W = 4;
  localparam int CONF_W = 17;
  localparam int OUT_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CONF_W;

  localparam logic [VOTE_W-1:0] VOTERS_RST = VOTE_W'(8);
  localparam logic [CONF_W-1:0] THRESH_RST = CONF_W'(32768);
  localparam logic [OUT_W-1:0]  NOISE_RST  = OUT_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOTERS = 2'd0,
    CFG_THRESH = 2'd1,
    CFG_NOISE  = 2'd2
  } cfg_idx_e;

endpackage

FILE: src/gplv_lane.sv
// gplv_lane: one voting lane, counts how many active lanes share its label
// standalone, widths come from parameters

module gplv_lane #(
  parameter int NUM_VOTERS  = 8,
  parameter int LABEL_WIDTH = 8,
  parameter int CNT_W       = 4,
  parameter int LANE_IDX    = 0
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [LABEL_WIDTH-1:0] labels_i [NUM_VOTERS],
  input  logic [NUM_VOTERS-1:0]  active_i,
  output logic [CNT_W-1:0]       cnt_o,
  output logic [LABEL_WIDTH-1:0] label_o
);

  logic [CNT_W-1:0]       cnt_d, cnt_q;
  logic [LABEL_WIDTH-1:0] label_q;

  // negative label or inactive lane abstains with a count of zero
  always_comb begin
    cnt_d = '0;
    if (active_i[LANE_IDX] && !labels_i[LANE_IDX][LABEL_WIDTH-1]) begin
      for (int j = 0; j < NUM_VOTERS; j++) begin
        if (active_i[j] && (labels_i[j] == labels_i[LANE_IDX])) begin
          cnt_d = cnt_d + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cnt_q   <= cnt_d;
      label_q <= labels_i[LANE_IDX];
    end
  end

  assign cnt_o   = cnt_q;
  assign label_o = label_q;

endmodule

FILE: src/gplv_merge.sv
// gplv_merge: picks the winning lane and applies the confidence gate
// depends on gplv_pkg

module gplv_merge #(
  parameter int NUM_VOTERS  = 8,
  parameter int LABEL_WIDTH = 8,
  parameter int CNT_W       = 4
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [CNT_W-1:0]            cnt_i   [NUM_VOTERS],
  input  logic [LABEL_WIDTH-1:0]      label_i [NUM_VOTERS],
  input  logic                        below_i,
  input  logic [gplv_pkg::OUT_W-1:0]  noise_i,
  output logic [gplv_pkg::OUT_W-1:0]  voted_label_o,
  output logic                        below_o
);

  import gplv_pkg::*;

  localparam int EXT_W = (LABEL_WIDTH > OUT_W) ? LABEL_WIDTH : OUT_W;

  logic [CNT_W-1:0]       best_cnt;
  logic [LABEL_WIDTH-1:0] best_lab;
  logic [EXT_W-1:0]       best_ext;
  logic [OUT_W-1:0]       label_d, label_q;
  logic                   below_q;

  // higher count wins, equal count goes to the smaller label
  always_comb begin
    best_cnt = '0;
    best_lab = '0;
    for (int i = 0; i < NUM_VOTERS; i++) begin
      if ((cnt_i[i] > best_cnt) ||
          ((cnt_i[i] == best_cnt) && (cnt_i[i] != '0) && (label_i[i] < best_lab))) begin
        best_cnt = cnt_i[i];
        best_lab = label_i[i];
      end
    end
    best_ext = EXT_W'(best_lab);
    label_d  = below_i ? noise_i : best_ext[OUT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      label_q <= label_d;
      below_q <= below_i;
    end
  end

  assign voted_label_o = label_q;
  assign below_o       = below_q;

endmodule

FILE: src/gated_plurality_label_vote.sv
// gated_plurality_label_vote: an item passes from the input transfer to the output
// through one lane-count stage and one merge stage.
// Throughput is one item per cycle; the lane compare stage and the merge
// register both advance every cycle unless the output is stalled.
// Reset clears both stage valid flags and loads the register defaults
// (8 voters, threshold 0.5, noise label 4).

module gated_plurality_label_vote #(
  parameter int NUM_VOTERS  = gplv_pkg::NUM_VOTERS_DEF,
  parameter int LABEL_WIDTH = gplv_pkg::LABEL_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gplv_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gplv_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [LABEL_WIDTH-1:0]           label_0_i,
  input  logic [LABEL_WIDTH-1:0]           label_1_i,
  input  logic [LABEL_WIDTH-1:0]           label_2_i,
  input  logic [LABEL_WIDTH-1:0]           label_3_i,
  input  logic [LABEL_WIDTH-1:0]           label_4_i,
  input  logic [LABEL_WIDTH-1:0]           label_5_i,
  input  logic [LABEL_WIDTH-1:0]           label_6_i,
  input  logic [LABEL_WIDTH-1:0]           label_7_i,
  input  logic [gplv_pkg::CONF_W-1:0]      confidence_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [gplv_pkg::OUT_W-1:0]       voted_label_o,
  output logic                             below_confidence_o
);

  import gplv_pkg::*;

  localparam int CNT_W = $clog2(NUM_VOTERS + 1);

  logic [VOTE_W-1:0] voters_q;
  logic [CONF_W-1:0] thresh_q;
  logic [OUT_W-1:0]  noise_q;

  logic                   s1_valid_q, out_valid_q;
  logic                   s1_below_q;
  logic                   out_en, s1_en, accept;
  logic [LABEL_WIDTH-1:0] all_lab  [LANE_COUNT];
  logic [LABEL_WIDTH-1:0] lane_lab [NUM_VOTERS];
  logic [NUM_VOTERS-1:0]  active;
  logic [CNT_W-1:0]       lane_cnt [NUM_VOTERS];
  logic [LABEL_WIDTH-1:0] lane_out [NUM_VOTERS];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voters_q <= VOTERS_RST;
      thresh_q <= THRESH_RST;
      noise_q  <= NOISE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_VOTERS: voters_q <= cfg_data_i[VOTE_W-1:0];
        CFG_THRESH: thresh_q <= cfg_data_i[CONF_W-1:0];
        CFG_NOISE:  noise_q  <= cfg_data_i[OUT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance, a stage moves when empty or when its successor moves
  assign out_en     = !out_valid_q || !out_stall_i;
  assign s1_en      = !s1_valid_q || out_en;
  assign accept     = in_valid_i && s1_en;
  assign in_stall_o = !s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_en) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_below_q <= !(confidence_i > thresh_q);
    end
  end

  assign all_lab[0] = label_0_i;
  assign all_lab[1] = label_1_i;
  assign all_lab[2] = label_2_i;
  assign all_lab[3] = label_3_i;
  assign all_lab[4] = label_4_i;
  assign all_lab[5] = label_5_i;
  assign all_lab[6] = label_6_i;
  assign all_lab[7] = label_7_i;

  // lanes past the configured count sit out; counts above the lane total saturate
  for (genvar g = 0; g < NUM_VOTERS; g++) begin : g_lane
    assign lane_lab[g] = all_lab[g];
    assign active[g]   = (voters_q > VOTE_W'(g));

    gplv_lane #(
      .NUM_VOTERS  (NUM_VOTERS),
      .LABEL_WIDTH (LABEL_WIDTH),
      .CNT_W       (CNT_W),
      .LANE_IDX    (g)
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (accept),
      .labels_i (lane_lab),
      .active_i (active),
      .cnt_o    (lane_cnt[g]),
      .label_o  (lane_out[g])
    );
  end

  gplv_merge #(
    .NUM_VOTERS  (NUM_VOTERS),
    .LABEL_WIDTH (LABEL_WIDTH),
    .CNT_W       (CNT_W)
  ) u_merge (
    .clk_i         (clk_i),
    .en_i          (out_en && s1_valid_q),
    .cnt_i         (lane_cnt),
    .label_i       (lane_out),
    .below_i       (s1_below_q),
    .noise_i       (noise_q),
    .voted_label_o (voted_label_o),
    .below_o       (below_confidence_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/gplv_chk.sv
// gplv_chk: port-level checks for gated_plurality_label_vote
// bound onto the top level at the end of this file

module gplv_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [gplv_pkg::OUT_W-1:0]   voted_label_o,
  input logic                         below_confidence_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(voted_label_o) && $stable(below_confidence_o))
    else $error("stalled result changed");

  // input is held off only while the output is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // a transfer followed by an unstalled output yields a valid result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("result missing after transfer");

  // a fresh result always traces back to an input transfer through the lane and merge registers
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a transfer");

endmodule

bind gated_plurality_label_vote gplv_chk u_gplv_chk (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for gated_plurality_label_vote, directed and random rows against a local vote model
// depends on gplv_pkg and gated_plurality_label_vote

module tb_top;
  import gplv_pkg::*;

  localparam int LW          = LABEL_WIDTH_DEF;
  localparam int NUM_V       = NUM_VOTERS_DEF;
  localparam int SETTLE      = 6;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;

  // index 3 has no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic [LANE_COUNT-1:0][LW-1:0] lab;
    logic [CONF_W-1:0]             conf;
  } row_t;

  typedef struct {
    logic [OUT_W-1:0] label;
    logic             below;
  } vote_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [LW-1:0]         label_0_i = '0;
  logic [LW-1:0]         label_1_i = '0;
  logic [LW-1:0]         label_2_i = '0;
  logic [LW-1:0]         label_3_i = '0;
  logic [LW-1:0]         label_4_i = '0;
  logic [LW-1:0]         label_5_i = '0;
  logic [LW-1:0]         label_6_i = '0;
  logic [LW-1:0]         label_7_i = '0;
  logic [CONF_W-1:0]     confidence_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [OUT_W-1:0]      voted_label_o;
  logic                  below_confidence_o;

  // local copy of the register file
  logic [VOTE_W-1:0] voters_cfg = VOTERS_RST;
  logic [CONF_W-1:0] thresh_cfg = THRESH_RST;
  logic [OUT_W-1:0]  noise_cfg  = NOISE_RST;

  row_t  pending_rows[$];
  vote_t pending_votes[$];
  row_t  cur_row;
  vote_t want;

  int  rows_sent = 0;
  int  rows_taken = 0;
  int  in_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  hold_reqs = 0;
  int  hold_seen = 0;
  int  err_cnt = 0;
  int  cycles = 0;
  bit  idling = 1'b0;

  gated_plurality_label_vote u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .label_0_i          (label_0_i),
    .label_1_i          (label_1_i),
    .label_2_i          (label_2_i),
    .label_3_i          (label_3_i),
    .label_4_i          (label_4_i),
    .label_5_i          (label_5_i),
    .label_6_i          (label_6_i),
    .label_7_i          (label_7_i),
    .confidence_i       (confidence_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .voted_label_o      (voted_label_o),
    .below_confidence_o (below_confidence_o)
  );

  always #5 clk_i = ~clk_i;

  // append at the tail of the pending queues
  function automatic void enqueue_row(input row_t r);
    pending_rows.insert(pending_rows.size(), r);
  endfunction

  function automatic void enqueue_vote(input vote_t v);
    pending_votes.insert(pending_votes.size(), v);
  endfunction

  // plurality among non-negative labels of the active lanes, smallest label wins a tie
  function automatic vote_t predict_vote(input logic [LANE_COUNT-1:0][LW-1:0] lab,
                                         input logic [CONF_W-1:0] conf);
    vote_t         res;
    int            used;
    int            hits;
    int            top_hits;
    logic [LW-1:0] top_lab;
    used = (voters_cfg > NUM_V) ? NUM_V : int'(voters_cfg);
    top_hits = 0;
    top_lab = '0;
    for (int i = 0; i < used; i++) begin
      if (!lab[i][LW-1]) begin
        hits = 0;
        for (int j = 0; j < used; j++) begin
          if (lab[j] == lab[i]) hits++;
        end
        if (hits > top_hits || (hits == top_hits && lab[i] < top_lab)) begin
          top_hits = hits;
          top_lab = lab[i];
        end
      end
    end
    if (conf > thresh_cfg) begin
      res.label = top_lab[OUT_W-1:0];
      res.below = 1'b0;
    end else begin
      res.label = noise_cfg;
      res.below = 1'b1;
    end
    return res;
  endfunction

  function automatic row_t mk_row(input logic [LANE_COUNT*LW-1:0] lanes,
                                  input logic [CONF_W-1:0] conf);
    row_t r;
    r.lab = lanes;
    r.conf = conf;
    return r;
  endfunction

  // labels drawn from a narrow window so pluralities and ties are common
  function automatic row_t rand_row();
    row_t r;
    int   span;
    int   base;
    span = $urandom_range(1, 6);
    base = $urandom_range(0, 120);
    for (int i = 0; i < LANE_COUNT; i++) begin
      case ($urandom_range(0, 9))
        0:       r.lab[i] = LW'($urandom);
        1, 2:    r.lab[i] = {1'b1, (LW-1)'($urandom)};
        default: r.lab[i] = LW'(base + $urandom_range(0, span));
      endcase
    end
    case ($urandom_range(0, 5))
      0:       r.conf = CONF_W'($urandom);
      1:       r.conf = CONF_W'($urandom_range(0, 65536));
      default: r.conf = thresh_cfg + CONF_W'($urandom_range(0, 40)) - CONF_W'(8);
    endcase
    return r;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_VOTERS: voters_cfg = data[VOTE_W-1:0];
      CFG_THRESH: thresh_cfg = data[CONF_W-1:0];
      CFG_NOISE:  noise_cfg = data[OUT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every queued row went through and every vote came back
  task automatic drain_all();
    while (pending_rows.size() != 0 || rows_taken != rows_sent || pending_votes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] voters, input logic [CFG_DATA_W-1:0] thresh,
                           input logic [CFG_DATA_W-1:0] noise, input int rows, input bit idle_mode);
    drain_all();
    cfg_write(CFG_VOTERS, voters);
    cfg_write(CFG_THRESH, thresh);
    cfg_write(CFG_NOISE, noise);
    idling = idle_mode;
    for (int k = 0; k < rows; k++) enqueue_row(rand_row());
  endtask

  // input side: hold the payload until the transfer, then maybe idle a while
  always @(negedge clk_i) begin
    if (rows_taken == rows_sent) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_rows.size() != 0) begin
        cur_row = pending_rows.pop_front();
        label_0_i <= cur_row.lab[0];
        label_1_i <= cur_row.lab[1];
        label_2_i <= cur_row.lab[2];
        label_3_i <= cur_row.lab[3];
        label_4_i <= cur_row.lab[4];
        label_5_i <= cur_row.lab[5];
        label_6_i <= cur_row.lab[6];
        label_7_i <= cur_row.lab[7];
        confidence_i <= cur_row.conf;
        in_valid_i <= 1'b1;
        rows_sent++;
        if (idling && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 18);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side stall: random bursts plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // check the output transfer first, then record the input transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_votes.size() == 0) begin
        $error("result with no row outstanding: voted_label %0d below_confidence %0d",
               voted_label_o, below_confidence_o);
        err_cnt++;
      end else begin
        want = pending_votes.pop_front();
        if (voted_label_o !== want.label) begin
          $error("voted_label: expected %0d, got %0d", want.label, voted_label_o);
          err_cnt++;
        end
        if (below_confidence_o !== want.below) begin
          $error("below_confidence: expected %0d, got %0d", want.below, below_confidence_o);
          err_cnt++;
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      enqueue_vote(predict_vote({label_7_i, label_6_i, label_5_i, label_4_i,
                                 label_3_i, label_2_i, label_1_i, label_0_i},
                                confidence_i));
      rows_taken++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    idling = 1'b1;

    // reset defaults: 8 voters, threshold 0.5, noise label 4
    enqueue_row(mk_row(64'h8080_8080_8080_8080, 17'd65536)); // nobody votes
    enqueue_row(mk_row(64'h7F7F_7F7F_7F7F_7F7F, 17'd65536));
    enqueue_row(mk_row(64'hFFFF_FFFF_0305_0305, 17'd40000)); // two-way tie
    enqueue_row(mk_row(64'h0700_0001_0102_0202, 17'd65536));
    enqueue_row(mk_row(64'h0203_0405_0607_0809, 17'd50000)); // all distinct
    enqueue_row(mk_row(64'h0000_0000_0000_0000, 17'd32768)); // conf equals threshold
    enqueue_row(mk_row(64'h01FF_FFFF_FFFF_FFFF, 17'd32769)); // only the last lane
    enqueue_row(mk_row(64'h0505_0505_0505_0505, 17'd0));
    enqueue_row(mk_row(64'h1A2B_3C4D_1A2B_3C4D, 17'h1FFFF)); // conf beyond 1.0
    enqueue_row(mk_row(64'h7E7E_7EFE_7FFF_7FFF, 17'd65535));
    enqueue_row(mk_row(64'hAA55_AA55_AA55_AA55, 17'd65535));
    enqueue_row(mk_row(64'h0A14_0A14_140A_140A, 17'd60000)); // four-four tie
    enqueue_row(mk_row(64'h0001_0203_0405_0607, 17'd60000));

    run_phase(17'd0, 17'd0, 17'd127, 220, 1'b1);
    run_phase(17'h1FFF1, 17'd65536, 17'd0, 220, 1'b1); // upper voter bits are dropped
    run_phase(17'd15, 17'h1FFFF, 17'd85, 220, 1'b1);   // too many lanes, vote never stands
    hold_reqs++;                                       // block fills and stalls its input
    run_phase(17'd9, 17'd1000, 17'h1FFFF, 220, 1'b0);

    drain_all();
    cfg_write(CFG_SPARE, 17'h1ABCD);
    run_phase(17'd5, 17'd32768, 17'd4, 110, 1'b1);
    drain_all();                                       // sender pauses until all votes are back
    for (int k = 0; k < 110; k++) enqueue_row(rand_row());

    run_phase(17'd3, 17'd49152, 17'd33, 220, 1'b1);
    run_phase(17'd6, 17'd20000, 17'd1, 220, 1'b1);
    run_phase(17'd8, 17'd32768, 17'd4, 340, 1'b0);
    drain_all();

    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
